@@ rtl/rcb_pkg.sv @@
// Shared types and constants of the residual context binarizer.
package rcb_pkg;

	// Width of the result stream data: decision bit and context id, padded to bytes.
	localparam int unsigned OUT_W = 16;

	// Neighbor sign class, 0 to 6.
	typedef logic [2:0] sclass_t;

	localparam sclass_t SCLASS_NONE   = 3'd0;
	localparam sclass_t SCLASS_PPN    = 3'd1;
	localparam sclass_t SCLASS_NNP    = 3'd2;
	localparam sclass_t SCLASS_PNN    = 3'd3;
	localparam sclass_t SCLASS_NPP    = 3'd4;
	localparam sclass_t SCLASS_ALLPOS = 3'd5;
	localparam sclass_t SCLASS_ALLNEG = 3'd6;

	// Context id bases and the offsets added for chroma.
	localparam logic [7:0] CTX_ZERO  = 8'd0;
	localparam logic [7:0] CTX_SIGN  = 8'd2;
	localparam logic [7:0] CTX_GT1   = 8'd9;
	localparam logic [7:0] CTX_CAT   = 8'd11;
	localparam logic [7:0] CTX_REF   = 8'd43;
	localparam logic [7:0] CAT_STEP  = 8'd16;
	localparam logic [7:0] REF_STEP  = 8'd48;

	// Reset value of the neighbor threshold register.
	localparam logic [7:0] THRESHOLD_RESET = 8'd1;

endpackage

@@ rtl/residual_context_binarizer.sv @@
// Residual context binarizer: turns 8x8 residual coefficients into context-tagged decisions.
//
// Coefficients enter one at a time in raster order on the s_ stream; each one is turned
// into 1 to 2*COEFF_BITS context-tagged binary decisions on the m_ stream, one decision
// per cycle while the output is not stalled, with m_tlast set on the last decision of a
// coefficient. A coefficient occupies the block until its last decision has been loaded
// into the output register; only then is the input ready again. The decisions come from
// the decision sequencer, which steps one shared compare-and-shift unit once per decision.
// The last nine coefficient values are kept as neighbor history and are zero after reset;
// the neighbor threshold register resets to 1 and should be written only while the block
// is idle.
module residual_context_binarizer #(
	parameter int unsigned COEFF_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// Configuration: neighbor_threshold.
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [7:0]                cfg_data,
	// Coefficient requests.
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// s_tdata, from bit 0: coefficient_value, coefficient_position, zero padding.
	input  logic [((COEFF_BITS+6+7)/8)*8-1:0] s_tdata,
	// s_tuser: is_chroma.
	input  logic                      s_tuser,
	// Decision requests.
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// m_tdata, from bit 0: decision_bit, context_id, zero padding.
	output logic [rcb_pkg::OUT_W-1:0] m_tdata,
	// m_tlast: last_of_coefficient.
	output logic                      m_tlast
);

	localparam int unsigned N    = COEFF_BITS;
	localparam int unsigned IW   = $clog2(COEFF_BITS);
	localparam int unsigned HIST = 9;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_ZERO = 6'b000010,
		ST_SIGN = 6'b000100,
		ST_GT1  = 6'b001000,
		ST_CAT  = 6'b010000,
		ST_REF  = 6'b100000
	} state_t;

	state_t                  state_q;
	state_t                  state_d;
	logic [7:0]              thresh_q;
	logic signed [N-1:0]     hist_q [HIST];
	logic [N-2:0]            sz_q;
	logic                    nz_q;
	logic                    neg_q;
	logic                    chroma_q;
	rcb_pkg::sclass_t        sclass_q;
	logic [IW-1:0]           i_q;
	logic [1:0]              l_q;
	logic [N-1:0]            m_q;
	logic                    out_valid_q;
	logic                    out_bit_q;
	logic [7:0]              out_ctx_q;
	logic                    out_last_q;

	logic                    accept;
	logic                    emit;
	logic signed [N-1:0]     in_val;
	logic [5:0]              in_pos;
	logic                    col_nz;
	logic                    row_nz;
	logic signed [N-1:0]     nb_left;
	logic signed [N-1:0]     nb_top;
	logic signed [N-1:0]     nb_ltop;
	rcb_pkg::sclass_t        sclass_d;
	logic [N-2:0]            sz_d;
	logic                    cat_ge;
	logic                    dec_bit;
	logic [7:0]              dec_ctx;
	logic                    dec_last;
	logic [7:0]              i_ext;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign emit      = (state_q != ST_IDLE) && (!out_valid_q || m_tready);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(rcb_pkg::OUT_W-9){1'b0}}, out_ctx_q, out_bit_q};
	assign m_tlast  = out_last_q;

	// Unpack the request and mask neighbors that fall outside the block.
	always_comb begin
		in_val  = $signed(s_tdata[N-1:0]);
		in_pos  = s_tdata[N+5:N];
		col_nz  = (in_pos[2:0] != 3'd0);
		row_nz  = (in_pos[5:3] != 3'd0);
		nb_left = col_nz ? hist_q[0] : '0;
		nb_top  = row_nz ? hist_q[7] : '0;
		nb_ltop = (col_nz && row_nz) ? hist_q[8] : '0;
		// Magnitude minus one: the one's complement for negative values.
		sz_d    = in_val[N-1] ? ~in_val[N-2:0] : (in_val[N-2:0] - {{(N-2){1'b0}}, 1'b1});
	end

	rcb_nbr_class #(
		.COEFF_BITS (N)
	) u_nbr (
		.left      (nb_left),
		.top       (nb_top),
		.ltop      (nb_ltop),
		.threshold (thresh_q),
		.sclass    (sclass_d)
	);

	// Shared compare unit and the decision of the current sequencer step.
	always_comb begin
		i_ext    = {{(8-IW){1'b0}}, i_q};
		cat_ge   = {1'b0, sz_q} >= m_q;
		dec_bit  = 1'b0;
		dec_ctx  = rcb_pkg::CTX_ZERO;
		dec_last = 1'b0;
		state_d  = state_q;
		case (state_q)
			ST_ZERO: begin
				dec_bit  = nz_q;
				dec_ctx  = rcb_pkg::CTX_ZERO + {7'd0, chroma_q};
				dec_last = !nz_q;
				state_d  = nz_q ? ST_SIGN : ST_IDLE;
			end
			ST_SIGN: begin
				dec_bit = neg_q;
				dec_ctx = rcb_pkg::CTX_SIGN + {5'd0, sclass_q};
				state_d = ST_GT1;
			end
			ST_GT1: begin
				dec_bit  = (sz_q != '0);
				dec_ctx  = rcb_pkg::CTX_GT1 + {7'd0, chroma_q};
				dec_last = (sz_q == '0);
				state_d  = (sz_q != '0) ? ST_CAT : ST_IDLE;
			end
			ST_CAT: begin
				dec_bit = cat_ge;
				dec_ctx = rcb_pkg::CTX_CAT + (chroma_q ? rcb_pkg::CAT_STEP : 8'd0) + i_ext;
				if (!cat_ge) begin
					dec_last = (i_q == '0);
					state_d  = (i_q == '0) ? ST_IDLE : ST_REF;
				end
			end
			ST_REF: begin
				dec_bit  = |({1'b0, sz_q} & m_q);
				dec_ctx  = rcb_pkg::CTX_REF + (chroma_q ? rcb_pkg::REF_STEP : 8'd0)
				           + {i_ext[6:0], 1'b0} + i_ext + {6'd0, l_q};
				dec_last = m_q[0];
				state_d  = m_q[0] ? ST_IDLE : ST_REF;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer state and the threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			thresh_q <= rcb_pkg::THRESHOLD_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				thresh_q <= cfg_data;
			end
			if (accept) begin
				state_q <= ST_ZERO;
			end else if (emit) begin
				state_q <= state_d;
			end
		end
	end

	// Neighbor history: a shift line of the received values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < HIST; k++) begin
				hist_q[k] <= '0;
			end
		end else if (accept) begin
			for (int k = HIST - 1; k > 0; k--) begin
				hist_q[k] <= hist_q[k-1];
			end
			hist_q[0] <= in_val;
		end
	end

	// Per-coefficient working registers; the mask register shifts once per category and refinement step.
	always_ff @(posedge clk) begin
		if (accept) begin
			sz_q     <= sz_d;
			nz_q     <= (in_val != '0);
			neg_q    <= in_val[N-1];
			chroma_q <= s_tuser;
			sclass_q <= sclass_d;
			i_q      <= '0;
			l_q      <= 2'd0;
			m_q      <= {{(N-2){1'b0}}, 2'b10};
		end else if (emit) begin
			case (state_q)
				ST_CAT: begin
					if (cat_ge) begin
						m_q <= {m_q[N-2:0], 1'b0};
						i_q <= i_q + {{(IW-1){1'b0}}, 1'b1};
					end else begin
						m_q <= {2'b00, m_q[N-1:2]};
					end
				end
				ST_REF: begin
					m_q <= {1'b0, m_q[N-1:1]};
					if (l_q != 2'd2) begin
						l_q <= l_q + 2'd1;
					end
				end
				default: begin
					m_q <= m_q;
				end
			endcase
		end
	end

	// Output register: valid under reset, payload loaded on each step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_bit_q  <= dec_bit;
			out_ctx_q  <= dec_ctx;
			out_last_q <= dec_last;
		end
	end

endmodule

@@ rtl/rcb_nbr_class.sv @@
// Neighbor sign classifier: compares left, top and top-left against the threshold.
module rcb_nbr_class #(
	parameter int unsigned COEFF_BITS = 16
) (
	input  logic signed [COEFF_BITS-1:0] left,
	input  logic signed [COEFF_BITS-1:0] top,
	input  logic signed [COEFF_BITS-1:0] ltop,
	input  logic        [7:0]            threshold,
	output rcb_pkg::sclass_t             sclass
);

	// Two extra bits hold both the unsigned threshold and its negation.
	localparam int unsigned CW = COEFF_BITS + 2;

	logic signed [CW-1:0] th_x;
	logic signed [CW-1:0] nth_x;
	logic signed [CW-1:0] l_x;
	logic signed [CW-1:0] t_x;
	logic signed [CW-1:0] d_x;
	logic lp, ln, tp, tn, dp, dn;

	// Extend operands to a common signed width.
	always_comb begin
		th_x  = $signed({{(CW-8){1'b0}}, threshold});
		nth_x = -th_x;
		l_x   = $signed({{2{left[COEFF_BITS-1]}}, left});
		t_x   = $signed({{2{top[COEFF_BITS-1]}}, top});
		d_x   = $signed({{2{ltop[COEFF_BITS-1]}}, ltop});
		lp    = l_x > th_x;
		ln    = l_x < nth_x;
		tp    = t_x > th_x;
		tn    = t_x < nth_x;
		dp    = d_x > th_x;
		dn    = d_x < nth_x;
	end

	// Pattern match in priority order; the first match wins.
	always_comb begin
		if (lp && dp && tn) begin
			sclass = rcb_pkg::SCLASS_PPN;
		end else if (ln && dn && tp) begin
			sclass = rcb_pkg::SCLASS_NNP;
		end else if (lp && dn && tn) begin
			sclass = rcb_pkg::SCLASS_PNN;
		end else if (ln && dp && tp) begin
			sclass = rcb_pkg::SCLASS_NPP;
		end else if (lp && tp && dp) begin
			sclass = rcb_pkg::SCLASS_ALLPOS;
		end else if (ln && tn && dn) begin
			sclass = rcb_pkg::SCLASS_ALLNEG;
		end else begin
			sclass = rcb_pkg::SCLASS_NONE;
		end
	end

endmodule

@@ rtl/rcb_chk.sv @@
// Port-level checker of the residual context binarizer and its bind.
module rcb_chk (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [rcb_pkg::OUT_W-1:0] m_tdata,
	input logic                      m_tlast
);

	// The input is not ready in the cycle after a coefficient is accepted.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after a coefficient was accepted");

	// A valid decision carries a context id in range and zero padding.
	a_ctx_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[8:1] <= 8'd138) && (m_tdata[rcb_pkg::OUT_W-1:9] == '0))
		else $error("decision with a context id out of range or nonzero padding");

	// While idle, a waiting decision can only be the last one of its coefficient.
	a_idle_holds_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready && m_tvalid |-> m_tlast)
		else $error("block idle with an unfinished coefficient on the output");

	// A stalled decision holds its payload.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled decision changed");

endmodule

bind residual_context_binarizer rcb_chk u_rcb_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

@@ tb/sv/tb_residual_context_binarizer.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the residual context binarizer with its own decision predictor.
module tb_residual_context_binarizer;

	localparam int unsigned LONG_HOLD = 300;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam longint unsigned TIMEOUT_NS = 10_000_000;

	// One expected decision on the output stream.
	typedef struct packed {
		logic       bit_val;
		logic [7:0] ctx;
		logic       last_flag;
	} decision_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [rcb_pkg::OUT_W-1:0] m_tdata;
	logic        m_tlast;

	// Predictor state: neighbor history and the threshold as the block holds it.
	logic signed [15:0] coeff_history [9] = '{default: '0};
	logic [7:0]         threshold_q = rcb_pkg::THRESHOLD_RESET;
	decision_t          expected_decisions [$];
	int                 errors = 0;

	// Stimulus state.
	bit         src_idle_en = 1'b1;
	bit         sink_idle_en = 1'b1;
	logic [7:0] stim_threshold = rcb_pkg::THRESHOLD_RESET;
	logic [5:0] next_pos = '0;
	logic       block_chroma = 1'b0;
	int         holds_requested = 0;
	int         holds_granted = 0;
	int         hold_left = 0;
	int         stall_left = 0;

	residual_context_binarizer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Sign pattern of the three neighbors; the first matching pattern wins.
	function automatic rcb_pkg::sclass_t neighbor_class(input int left, input int top,
			input int ltop, input int th);
		bit lp, ln, tp, tn, dp, dn;
		lp = left > th;
		ln = left < -th;
		tp = top > th;
		tn = top < -th;
		dp = ltop > th;
		dn = ltop < -th;
		if (lp && dp && tn)
			return rcb_pkg::SCLASS_PPN;
		else if (ln && dn && tp)
			return rcb_pkg::SCLASS_NNP;
		else if (lp && dn && tn)
			return rcb_pkg::SCLASS_PNN;
		else if (ln && dp && tp)
			return rcb_pkg::SCLASS_NPP;
		else if (lp && tp && dp)
			return rcb_pkg::SCLASS_ALLPOS;
		else if (ln && tn && dn)
			return rcb_pkg::SCLASS_ALLNEG;
		return rcb_pkg::SCLASS_NONE;
	endfunction

	function automatic void queue_decision(input logic bit_val, input logic [7:0] ctx);
		decision_t d;
		d.bit_val = bit_val;
		d.ctx = ctx;
		d.last_flag = 1'b0;
		expected_decisions.push_back(d);
	endfunction

	// Works out the decisions of one coefficient and shifts it into the history.
	task automatic predict_decisions(input logic signed [15:0] value, input logic [5:0] pos,
			input logic chroma);
		int left, top, ltop, mag_m1, step, cat, lvl, b, k;
		rcb_pkg::sclass_t sc;
		logic [7:0] c8;
		c8 = {7'b0, chroma};
		left = (pos[2:0] != 0) ? int'(coeff_history[0]) : 0;
		top = (pos[5:3] != 0) ? int'(coeff_history[7]) : 0;
		ltop = (pos[2:0] != 0 && pos[5:3] != 0) ? int'(coeff_history[8]) : 0;
		sc = neighbor_class(left, top, ltop, int'(threshold_q));
		if (value == 0) begin
			queue_decision(1'b0, rcb_pkg::CTX_ZERO + c8);
		end else begin
			queue_decision(1'b1, rcb_pkg::CTX_ZERO + c8);
			queue_decision(value < 0, rcb_pkg::CTX_SIGN + {5'b0, sc});
			mag_m1 = (value < 0) ? -int'(value) - 1 : int'(value) - 1;
			if (mag_m1 == 0) begin
				queue_decision(1'b0, rcb_pkg::CTX_GT1 + c8);
			end else begin
				queue_decision(1'b1, rcb_pkg::CTX_GT1 + c8);
				// Unary category: one bit per doubling that the magnitude reaches.
				cat = 0;
				step = 2;
				while (mag_m1 >= step) begin
					queue_decision(1'b1, rcb_pkg::CTX_CAT + rcb_pkg::CAT_STEP * c8 + 8'(cat));
					step = step << 1;
					cat++;
				end
				queue_decision(1'b0, rcb_pkg::CTX_CAT + rcb_pkg::CAT_STEP * c8 + 8'(cat));
				// Refinement bits below the leading one, most significant first.
				lvl = 0;
				for (b = cat - 1; b >= 0; b--) begin
					queue_decision(mag_m1[b],
						rcb_pkg::CTX_REF + rcb_pkg::REF_STEP * c8 + 8'(3 * cat + lvl));
					if (lvl < 2)
						lvl++;
				end
			end
		end
		expected_decisions[expected_decisions.size() - 1].last_flag = 1'b1;
		for (k = 8; k > 0; k--)
			coeff_history[k] = coeff_history[k - 1];
		coeff_history[0] = value;
	endtask

	// Tracks accepted requests and checks every decision against the oldest expectation.
	always @(posedge clk) begin
		decision_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				threshold_q = cfg_data;
			if (s_tvalid && s_tready)
				predict_decisions(s_tdata[15:0], s_tdata[21:16], s_tuser);
			if (m_tvalid && m_tready) begin
				if (expected_decisions.size() == 0) begin
					$error("unexpected decision: data=%h last=%b", m_tdata, m_tlast);
					errors++;
				end else begin
					want = expected_decisions.pop_front();
					if (m_tdata[0] !== want.bit_val) begin
						$error("decision_bit: expected %0d, got %0d", want.bit_val, m_tdata[0]);
						errors++;
					end
					if (m_tdata[8:1] !== want.ctx) begin
						$error("context_id: expected %0d, got %0d", want.ctx, m_tdata[8:1]);
						errors++;
					end
					if (m_tlast !== want.last_flag) begin
						$error("last_of_coefficient: expected %0d, got %0d", want.last_flag,
							m_tlast);
						errors++;
					end
					if (m_tdata[rcb_pkg::OUT_W-1:9] !== '0) begin
						$error("padding: expected 0, got %h", m_tdata[rcb_pkg::OUT_W-1:9]);
						errors++;
					end
				end
			end
		end
	end

	// Decision receiver: long hold-offs on request, random stall bursts otherwise.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (holds_granted != holds_requested) begin
			holds_granted++;
			hold_left = LONG_HOLD - 1;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 14) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Offers one coefficient request and returns at the edge that accepts it.
	task automatic send_coeff(input logic signed [15:0] value, input logic [5:0] pos,
			input logic chroma);
		if (src_idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, pos, value};
		s_tuser <= chroma;
		do
			@(posedge clk);
		while (!(s_tvalid && s_tready));
	endtask

	// Stops offering and waits until every expected decision has arrived.
	task automatic wait_all_decisions();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_decisions.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_threshold(input logic [7:0] th);
		wait_all_decisions();
		cfg_valid <= 1'b1;
		cfg_data <= th;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		stim_threshold = th;
	endtask

	// Values are zero, random over the full range or near the threshold, so that every neighbor sign pattern shows up.
	function automatic logic signed [15:0] random_coeff(input logic [7:0] th);
		int sel, mag;
		sel = $urandom_range(0, 99);
		if (sel < 30)
			return 16'sd0;
		if (sel < 80)
			return 16'($urandom);
		if (sel < 90)
			mag = int'(th) + $urandom_range(1, 6);
		else
			mag = $urandom_range(0, int'(th));
		return $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
	endfunction

	// Mostly blocks in raster order with random content, some items at random positions.
	task automatic send_random_coeffs(input int count);
		int k;
		for (k = 0; k < count; k++) begin
			if ($urandom_range(0, 99) < 10) begin
				send_coeff(random_coeff(stim_threshold), 6'($urandom_range(0, 63)),
					1'($urandom_range(0, 1)));
			end else begin
				if (next_pos == 0)
					block_chroma = 1'($urandom_range(0, 1));
				send_coeff(random_coeff(stim_threshold), next_pos, block_chroma);
				next_pos++;
			end
		end
	endtask

	// Extremes of value, every decision kind, block edges and positions out of order.
	task automatic test_directed_extremes();
		logic signed [15:0] vals [19] = '{0, 1, -1, 2, -2, 3, 32767, -32768, -3, 4, -32767,
			16384, -16385, 2, -5, 7, 1, -1, 255};
		logic [5:0] poss [19] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 63, 0,
			62};
		logic chromas [19] = '{0, 1, 0, 1, 0, 1, 0, 1, 0, 1, 0, 1, 0, 0, 1, 0, 1, 0, 0};
		int k;
		for (k = 0; k < 19; k++)
			send_coeff(vals[k], poss[k], chromas[k]);
	endtask

	task automatic test_zero_threshold();
		write_threshold(8'd0);
		send_random_coeffs(100);
	endtask

	task automatic test_max_threshold();
		write_threshold(8'd255);
		send_random_coeffs(90);
	endtask

	// The receiver holds off while the sender keeps offering, then the sender drains.
	task automatic test_backpressure();
		write_threshold(8'($urandom_range(2, 254)));
		src_idle_en = 1'b0;
		holds_requested++;
		send_random_coeffs(30);
		src_idle_en = 1'b1;
		wait_all_decisions();
		send_random_coeffs(10);
	endtask

	task automatic test_random_threshold();
		write_threshold(8'($urandom_range(0, 255)));
		send_random_coeffs(100);
	endtask

	task automatic test_streaming_no_idle();
		write_threshold(8'($urandom_range(1, 8)));
		src_idle_en = 1'b0;
		sink_idle_en = 1'b0;
		send_random_coeffs(80);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_zero_threshold();
		test_max_threshold();
		test_backpressure();
		test_random_threshold();
		test_streaming_no_idle();
		wait_all_decisions();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog in case the block stops answering.
	initial begin
		#(TIMEOUT_NS);
		$display("Simulation FAILED");
		$finish;
	end

endmodule
